### hw/rtl/bbe_pkg.sv
// Package for the edge-aware 3x3 box blur: pixel, column and result types,
// configuration and opcode codes, and the rounding mean arithmetic.
// No dependencies.
package bbe_pkg;

    localparam int FW_W        = 11;
    localparam int FH_W        = 13;
    localparam int CFG_DATA_W  = 13;
    localparam int CH_W        = 8;
    localparam int CSUM_W      = 10;
    localparam int SUM_W       = 12;
    localparam int CNT_W       = 4;
    localparam int RECIP_W     = 17;
    localparam int RECIP_SHIFT = 16;
    localparam int PROD_W      = SUM_W + RECIP_W;
    localparam int QUEUE_DEPTH = 4;
    localparam int Q_PTR_W     = 2;
    localparam int Q_CNT_W     = 3;
    localparam int WIN_COLS    = 2;

    localparam logic [FW_W-1:0] FW_RESET = 11'd1024;
    localparam logic [FH_W-1:0] FH_RESET = 13'd1024;

    localparam logic CFG_FRAME_WIDTH  = 1'b0;
    localparam logic CFG_FRAME_HEIGHT = 1'b1;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } t_pix;

    typedef struct packed {
        t_pix top;
        t_pix mid;
        t_pix bot;
    } t_col;

    typedef struct packed {
        logic top_en;
        logic bot_en;
    } t_mask;

    typedef struct packed {
        logic [CSUM_W-1:0] red;
        logic [CSUM_W-1:0] green;
        logic [CSUM_W-1:0] blue;
    } t_csum;

    typedef struct packed {
        logic [SUM_W-1:0] red;
        logic [SUM_W-1:0] green;
        logic [SUM_W-1:0] blue;
    } t_sum;

    typedef struct packed {
        logic             valid;
        t_sum             total;
        logic [CNT_W-1:0] cnt;
        logic             frame_end;
    } t_acc;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
        logic            frame_end;
    } t_res;

    function automatic logic [CSUM_W-1:0] chan_sum(logic [CH_W-1:0] top, logic [CH_W-1:0] mid,
                                                   logic [CH_W-1:0] bot, t_mask mask);
        logic [CSUM_W-1:0] s;
        s = CSUM_W'(mid);
        if (mask.top_en) begin
            s = s + CSUM_W'(top);
        end
        if (mask.bot_en) begin
            s = s + CSUM_W'(bot);
        end
        return s;
    endfunction

    function automatic t_csum col_sum(t_col col, t_mask mask);
        t_csum s;
        s.red   = chan_sum(col.top.red, col.mid.red, col.bot.red, mask);
        s.green = chan_sum(col.top.green, col.mid.green, col.bot.green, mask);
        s.blue  = chan_sum(col.top.blue, col.mid.blue, col.bot.blue, mask);
        return s;
    endfunction

    // Reciprocals are ceil(2^16 / n); the error stays below 1/n for sums up to 2299.
    function automatic logic [RECIP_W-1:0] recip(logic [CNT_W-1:0] cnt);
        logic [RECIP_W-1:0] r;
        case (cnt)
            4'd1:    r = 17'd65536;
            4'd2:    r = 17'd32768;
            4'd3:    r = 17'd21846;
            4'd4:    r = 17'd16384;
            4'd6:    r = 17'd10923;
            4'd9:    r = 17'd7282;
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic logic [CH_W-1:0] round_mean(logic [SUM_W-1:0] total,
                                                   logic [CNT_W-1:0] cnt);
        logic [SUM_W-1:0]  biased;
        logic [PROD_W-1:0] prod;
        biased = total + SUM_W'(cnt >> 1);
        prod   = PROD_W'(biased) * PROD_W'(recip(cnt));
        return prod[RECIP_SHIFT +: CH_W];
    endfunction

    function automatic t_res make_res(t_acc acc);
        t_res res;
        res.red       = round_mean(acc.total.red, acc.cnt);
        res.green     = round_mean(acc.total.green, acc.cnt);
        res.blue      = round_mean(acc.total.blue, acc.cnt);
        res.frame_end = acc.frame_end;
        return res;
    endfunction

endpackage

### hw/rtl/bbe_stream_if.sv
// Stream interfaces of the box blur: pixel items in and result words out.
// Depends on bbe_pkg for the channel width.
interface bbe_pix_if import bbe_pkg::*;;
    logic            valid;
    logic            ready;
    logic            opcode;
    logic [CH_W-1:0] red_in;
    logic [CH_W-1:0] green_in;
    logic [CH_W-1:0] blue_in;

    modport source (output valid, output opcode, output red_in, output green_in,
                    output blue_in, input ready);
    modport sink (input valid, input opcode, input red_in, input green_in,
                  input blue_in, output ready);
endinterface

interface bbe_res_if import bbe_pkg::*;;
    logic            valid;
    logic            ready;
    logic [CH_W-1:0] red_out;
    logic [CH_W-1:0] green_out;
    logic [CH_W-1:0] blue_out;
    logic            frame_end;

    modport source (output valid, output red_out, output green_out, output blue_out,
                    output frame_end, input ready);
    modport sink (input valid, input red_out, input green_out, input blue_out,
                  input frame_end, output ready);
endinterface

### hw/rtl/bbe_line_store.sv
// Line store: one write port and two registered read ports with write bypass.
// Depends on bbe_pkg for the pixel type.
module bbe_line_store import bbe_pkg::*; #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_pix          i_wdata,
    input  logic [AW-1:0] i_raddr_a,
    input  logic [AW-1:0] i_raddr_b,
    output t_pix          o_rdata_a,
    output t_pix          o_rdata_b
);

    t_pix r_mem [DEPTH];
    t_pix r_rdata_a;
    t_pix r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_we && (i_waddr == i_raddr_a)) begin
            r_rdata_a <= i_wdata;
        end else begin
            r_rdata_a <= r_mem[i_raddr_a];
        end
        if (i_we && (i_waddr == i_raddr_b)) begin
            r_rdata_b <= i_wdata;
        end else begin
            r_rdata_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

### hw/rtl/bbe_win_cell.sv
// Window cell: holds one column of three pixels, hands it on when the window
// shifts, and forms the masked column sum. Depends on bbe_pkg.
module bbe_win_cell import bbe_pkg::*; (
    input  logic  i_clk,
    input  logic  i_shift,
    input  t_col  i_col,
    input  t_mask i_mask,
    output t_col  o_col,
    output t_csum o_sum
);

    t_col r_col;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_col <= i_col;
        end
    end

    assign o_col = r_col;
    assign o_sum = col_sum(r_col, i_mask);

endmodule

### hw/rtl/bbe_out_queue.sv
// Output queue: turns up to two summed results a cycle into rounded means and
// holds them until the result side takes them. Depends on bbe_pkg, bbe_stream_if.
module bbe_out_queue import bbe_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_acc               i_acc_a,
    input  t_acc               i_acc_b,
    output logic [Q_CNT_W-1:0] o_free,
    bbe_res_if.source          o_res
);

    t_res                r_q [QUEUE_DEPTH];
    logic [Q_PTR_W-1:0]  r_head;
    logic [Q_PTR_W-1:0]  r_tail;
    logic [Q_CNT_W-1:0]  r_count;
    logic [Q_PTR_W-1:0]  n_head;
    logic [Q_PTR_W-1:0]  n_tail;
    logic [Q_CNT_W-1:0]  n_count;
    logic [Q_PTR_W-1:0]  addr_b;
    logic                pop;
    t_res                res_a;
    t_res                res_b;

    assign pop = o_res.valid && o_res.ready;

    always_comb begin
        res_a   = make_res(i_acc_a);
        res_b   = make_res(i_acc_b);
        addr_b  = r_tail + Q_PTR_W'(i_acc_a.valid);
        n_tail  = addr_b + Q_PTR_W'(i_acc_b.valid);
        n_head  = r_head + Q_PTR_W'(pop);
        n_count = r_count + Q_CNT_W'(i_acc_a.valid) + Q_CNT_W'(i_acc_b.valid)
                  - Q_CNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_acc_a.valid) begin
            r_q[r_tail] <= res_a;
        end
        if (i_acc_b.valid) begin
            r_q[addr_b] <= res_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    assign o_free          = Q_CNT_W'(QUEUE_DEPTH) - r_count;
    assign o_res.valid     = (r_count != '0);
    assign o_res.red_out   = r_q[r_head].red;
    assign o_res.green_out = r_q[r_head].green;
    assign o_res.blue_out  = r_q[r_head].blue;
    assign o_res.frame_end = r_q[r_head].frame_end;

endmodule

### hw/rtl/box_blur_3x3_edge_aware_core.sv
// Streaming 3x3 box blur over RGB pixels with the window clipped to the frame.
// Depends on bbe_pkg, bbe_stream_if, bbe_line_store, bbe_win_cell and bbe_out_queue.
// Words go via r_acc_a/r_acc_b and the output queue to o_res. Throughput: one item per cycle
// while i_pix.ready is high; a row-end pixel off row 0 and column 0 yields two words, so the
// four-entry queue can hold i_pix.ready low for one cycle even when o_res is always ready.
// Synchronous active-low reset clears positions, pipeline and queue and sets a 1024x1024 frame.
module box_blur_3x3_edge_aware_core import bbe_pkg::*; #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    bbe_pix_if.sink               i_pix,
    bbe_res_if.source             o_res
);

    localparam int AW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WW  = $clog2(MAX_WIDTH + 1);
    localparam int CW  = (WW > FW_W) ? WW : FW_W;
    localparam int RW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int HW  = $clog2(MAX_HEIGHT + 1);
    localparam int CHW = (HW > FH_W) ? HW : FH_W;

    logic [FW_W-1:0] r_frame_width;
    logic [FH_W-1:0] r_frame_height;
    logic [AW-1:0]   r_col;
    logic [RW-1:0]   r_row;
    logic [AW-1:0]   r_drain;
    logic            r_draining;
    t_acc            r_acc_a;
    t_acc            r_acc_b;

    logic [FW_W-1:0] n_frame_width;
    logic [FH_W-1:0] n_frame_height;
    logic [AW-1:0]   n_col;
    logic [RW-1:0]   n_row;
    logic [AW-1:0]   n_drain;
    logic            n_draining;
    t_acc            n_acc_a;
    t_acc            n_acc_b;

    logic [WW-1:0]      used_w;
    logic [HW-1:0]      used_h;
    logic               acc_in;
    logic               pix_go;
    logic               drain_go;
    logic               col_last;
    logic               drain_last;
    logic               row_last;
    logic               row_ge1;
    logic               row_ge2;
    logic [AW-1:0]      rd_a;
    logic [AW-1:0]      rd_b;
    t_pix               cur;
    t_pix               older_a;
    t_pix               older_b;
    t_pix               prev_a;
    t_pix               prev_b;
    t_col               in_col;
    t_col               right_col;
    t_mask              mask;
    t_csum              sum_in;
    t_csum              sum_x;
    t_csum              sum_right;
    logic               en_x;
    logic               en_0;
    logic [1:0]         rows;
    logic [1:0]         s1_cnt;
    logic [Q_CNT_W-1:0] q_free;
    t_col               chain_in [WIN_COLS];
    t_col               cell_col [WIN_COLS];
    t_csum              cell_sum [WIN_COLS];

    function automatic logic [SUM_W-1:0] add_chan(logic [CSUM_W-1:0] a, logic a_en,
                                                  logic [CSUM_W-1:0] b, logic b_en,
                                                  logic [CSUM_W-1:0] c);
        logic [SUM_W-1:0] s;
        s = SUM_W'(c);
        if (a_en) begin
            s = s + SUM_W'(a);
        end
        if (b_en) begin
            s = s + SUM_W'(b);
        end
        return s;
    endfunction

    function automatic t_sum add_cols(t_csum a, logic a_en, t_csum b, logic b_en, t_csum c);
        t_sum s;
        s.red   = add_chan(a.red, a_en, b.red, b_en, c.red);
        s.green = add_chan(a.green, a_en, b.green, b_en, c.green);
        s.blue  = add_chan(a.blue, a_en, b.blue, b_en, c.blue);
        return s;
    endfunction

    always_comb begin
        if (r_frame_width == '0) begin
            used_w = WW'(1);
        end else if (CW'(r_frame_width) > CW'(MAX_WIDTH)) begin
            used_w = WW'(MAX_WIDTH);
        end else begin
            used_w = WW'(r_frame_width);
        end
        if (r_frame_height == '0) begin
            used_h = HW'(1);
        end else if (CHW'(r_frame_height) > CHW'(MAX_HEIGHT)) begin
            used_h = HW'(MAX_HEIGHT);
        end else begin
            used_h = HW'(r_frame_height);
        end
    end

    assign acc_in     = i_pix.valid && i_pix.ready;
    assign pix_go     = acc_in && (i_pix.opcode == OP_PIXEL) && !r_draining;
    assign drain_go   = acc_in && (i_pix.opcode == OP_DRAIN) && r_draining;
    assign col_last   = ((WW'(r_col) + WW'(1)) == used_w);
    assign drain_last = ((WW'(r_drain) + WW'(1)) == used_w);
    assign row_last   = ((HW'(r_row) + HW'(1)) == used_h);
    assign row_ge1    = (r_row != '0);
    assign row_ge2    = (32'(r_row) >= 32'd2);

    always_comb begin
        n_frame_width  = r_frame_width;
        n_frame_height = r_frame_height;
        n_col          = r_col;
        n_row          = r_row;
        n_drain        = r_drain;
        n_draining     = r_draining;
        if (i_cfg_we) begin
            if (i_cfg_idx == CFG_FRAME_WIDTH) begin
                n_frame_width = i_cfg_data[FW_W-1:0];
            end else if (i_cfg_idx == CFG_FRAME_HEIGHT) begin
                n_frame_height = i_cfg_data[FH_W-1:0];
            end
            n_col      = '0;
            n_row      = '0;
            n_drain    = '0;
            n_draining = 1'b0;
        end else if (pix_go) begin
            if (col_last) begin
                n_col = '0;
                if (row_last) begin
                    n_row      = '0;
                    n_draining = 1'b1;
                    n_drain    = '0;
                end else begin
                    n_row = r_row + RW'(1);
                end
            end else begin
                n_col = r_col + AW'(1);
            end
        end else if (drain_go) begin
            if (drain_last) begin
                n_drain    = '0;
                n_draining = 1'b0;
            end else begin
                n_drain = r_drain + AW'(1);
            end
        end
    end

    // Port a of both stores is read at the position of the next item and port b one past the next
    // drain position, so their data always matches the current position and, for drains, the next one.
    always_comb begin
        if (!i_rst_n) begin
            rd_a = '0;
            rd_b = AW'(1);
        end else begin
            rd_a = n_draining ? n_drain : n_col;
            rd_b = n_drain + AW'(1);
        end
    end

    assign cur = '{red: i_pix.red_in, green: i_pix.green_in, blue: i_pix.blue_in};

    bbe_line_store #(.DEPTH(MAX_WIDTH), .AW(AW)) u_older_store (
        .i_clk     (i_clk),
        .i_we      (pix_go),
        .i_waddr   (r_col),
        .i_wdata   (prev_a),
        .i_raddr_a (rd_a),
        .i_raddr_b (rd_b),
        .o_rdata_a (older_a),
        .o_rdata_b (older_b)
    );

    bbe_line_store #(.DEPTH(MAX_WIDTH), .AW(AW)) u_prev_store (
        .i_clk     (i_clk),
        .i_we      (pix_go),
        .i_waddr   (r_col),
        .i_wdata   (cur),
        .i_raddr_a (rd_a),
        .i_raddr_b (rd_b),
        .o_rdata_a (prev_a),
        .o_rdata_b (prev_b)
    );

    assign mask.top_en = r_draining ? (used_h != HW'(1)) : row_ge2;
    assign mask.bot_en = !r_draining;
    assign in_col      = '{top: older_a, mid: prev_a, bot: cur};
    assign right_col   = '{top: older_b, mid: prev_b, bot: cur};
    assign sum_in      = col_sum(in_col, mask);
    assign sum_right   = col_sum(right_col, mask);

    genvar k;
    for (k = 0; k < WIN_COLS; k++) begin : g_win
        if (k == 0) begin : g_head
            assign chain_in[k] = in_col;
        end else begin : g_link
            assign chain_in[k] = cell_col[k-1];
        end
        bbe_win_cell u_win_cell (
            .i_clk   (i_clk),
            .i_shift (pix_go || drain_go),
            .i_col   (chain_in[k]),
            .i_mask  (mask),
            .o_col   (cell_col[k]),
            .o_sum   (cell_sum[k])
        );
    end

    always_comb begin
        sum_x = r_draining ? sum_right : cell_sum[WIN_COLS-1];
        en_x  = r_draining ? !drain_last : (32'(r_col) >= 32'd2);
        en_0  = r_draining ? (r_drain != '0) : 1'b1;
        rows  = 2'd1 + 2'(mask.top_en) + 2'(mask.bot_en);

        n_acc_a.valid     = pix_go ? (row_ge1 && (r_col != '0)) : drain_go;
        n_acc_a.total     = add_cols(sum_x, en_x, cell_sum[0], en_0, sum_in);
        n_acc_a.cnt       = CNT_W'(rows) * (CNT_W'(1) + CNT_W'(en_x) + CNT_W'(en_0));
        n_acc_a.frame_end = drain_go && drain_last;

        n_acc_b.valid     = pix_go && row_ge1 && col_last;
        n_acc_b.total     = add_cols(sum_x, 1'b0, cell_sum[0], r_col != '0, sum_in);
        n_acc_b.cnt       = CNT_W'(rows) * (CNT_W'(1) + CNT_W'(r_col != '0));
        n_acc_b.frame_end = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        r_acc_a <= n_acc_a;
        r_acc_b <= n_acc_b;
        if (!i_rst_n) begin
            r_frame_width  <= FW_RESET;
            r_frame_height <= FH_RESET;
            r_col          <= '0;
            r_row          <= '0;
            r_drain        <= '0;
            r_draining     <= 1'b0;
            r_acc_a.valid  <= 1'b0;
            r_acc_b.valid  <= 1'b0;
        end else begin
            r_frame_width  <= n_frame_width;
            r_frame_height <= n_frame_height;
            r_col          <= n_col;
            r_row          <= n_row;
            r_drain        <= n_drain;
            r_draining     <= n_draining;
        end
    end

    bbe_out_queue u_out_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_acc_a (r_acc_a),
        .i_acc_b (r_acc_b),
        .o_free  (q_free),
        .o_res   (o_res)
    );

    assign s1_cnt      = 2'(r_acc_a.valid) + 2'(r_acc_b.valid);
    assign i_pix.ready = (q_free >= (Q_CNT_W'(s1_cnt) + Q_CNT_W'(2)));

endmodule

### hw/rtl/bbe_checker.sv
// Port-level checks for the box blur core, bound to the top level.
// Depends on box_blur_3x3_edge_aware_core and its stream interfaces.
module bbe_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready
);

    a_reset_empties: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("A word is offered right after reset.");

    a_reset_ready: assert property (@(posedge i_clk) !i_rst_n |=> i_in_ready)
        else $error("The input is not ready right after reset.");

    a_word_has_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(i_in_valid && i_in_ready, 2))
        else $error("A word appeared without an item accepted two cycles before.");

    a_out_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("A stalled word was withdrawn.");

endmodule

bind box_blur_3x3_edge_aware_core bbe_checker u_bbe_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_pix.valid),
    .i_in_ready  (i_pix.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready)
);

### test/testbench.sv
// Self-checking testbench for box_blur_3x3_edge_aware_core: random and directed pixel
// frames with drains, compared against an in-bench blur predictor.
// Depends on bbe_pkg, bbe_stream_if and the core RTL.
`timescale 1ns / 100ps

module testbench;
    import bbe_pkg::*;

    localparam int MAX_W         = 1024;
    localparam int MAX_H         = 4096;
    localparam int SETTLE_CYCLES = 8;
    localparam int STALL_LIMIT   = 2000;
    localparam int ITEM_TARGET   = 1400;

    typedef struct packed {
        logic opcode;
        t_pix px;
    } pix_word_t;

    typedef struct {
        int unsigned red;
        int unsigned green;
        int unsigned blue;
        int unsigned n;
    } chan_sums_t;

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_cfg_we   = 1'b0;
    logic                  i_cfg_idx  = CFG_FRAME_WIDTH;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    logic      pix_valid = 1'b0;
    pix_word_t on_bus    = '0;
    logic      res_ready = 1'b0;

    bbe_pix_if pix_bus ();
    bbe_res_if res_bus ();

    assign pix_bus.valid    = pix_valid;
    assign pix_bus.opcode   = on_bus.opcode;
    assign pix_bus.red_in   = on_bus.px.red;
    assign pix_bus.green_in = on_bus.px.green;
    assign pix_bus.blue_in  = on_bus.px.blue;
    assign res_bus.ready    = res_ready;

    box_blur_3x3_edge_aware_core #(
        .MAX_WIDTH  (MAX_W),
        .MAX_HEIGHT (MAX_H)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_pix      (pix_bus),
        .o_res      (res_bus)
    );

    always #10 i_clk = ~i_clk;

    // Predictor state: line stores, window, positions and configuration.
    t_pix            older_rows [MAX_W];
    t_pix            prev_rows  [MAX_W];
    t_pix            win_px     [6];
    int unsigned     row_pos    = 0;
    int unsigned     col_pos    = 0;
    int unsigned     drain_pos  = 0;
    bit              draining   = 1'b0;
    logic [FW_W-1:0] cfg_width  = FW_RESET;
    logic [FH_W-1:0] cfg_height = FH_RESET;

    pix_word_t   pending_words [$];
    t_res        blur_expected [$];
    int unsigned bad_words     = 0;
    int unsigned results_seen  = 0;
    int unsigned hold_left     = 0;
    int unsigned cycle_cnt     = 0;
    int unsigned stall_cycles  = 0;

    function automatic int unsigned used_width();
        if (cfg_width == 0) return 1;
        if (cfg_width > MAX_W) return MAX_W;
        return cfg_width;
    endfunction

    function automatic int unsigned used_height();
        if (cfg_height == 0) return 1;
        if (cfg_height > MAX_H) return MAX_H;
        return cfg_height;
    endfunction

    function automatic chan_sums_t add_px(chan_sums_t s, t_pix p);
        s.red   += p.red;
        s.green += p.green;
        s.blue  += p.blue;
        s.n     += 1;
        return s;
    endfunction

    function automatic t_res blur_word(chan_sums_t s, logic fe);
        t_res w;
        w.red       = 8'((s.red + s.n / 2) / s.n);
        w.green     = 8'((s.green + s.n / 2) / s.n);
        w.blue      = 8'((s.blue + s.n / 2) / s.n);
        w.frame_end = fe;
        return w;
    endfunction

    function automatic void blur_predict(pix_word_t w);
        int unsigned wd, ht, r, c, d, lo, hi, x;
        t_pix        o, p;
        chan_sums_t  s;
        wd = used_width();
        ht = used_height();
        if (w.opcode == OP_DRAIN) begin
            if (!draining || drain_pos >= wd) return;
            d  = drain_pos;
            lo = (d >= 1) ? d - 1 : 0;
            hi = (d + 1 < wd) ? d + 1 : d;
            s  = '{0, 0, 0, 0};
            for (x = lo; x <= hi; x++) begin
                if (ht >= 2) s = add_px(s, older_rows[x]);
                s = add_px(s, prev_rows[x]);
            end
            blur_expected.push_back(blur_word(s, d == wd - 1));
            d++;
            if (d >= wd) begin
                d        = 0;
                draining = 1'b0;
            end
            drain_pos = d;
            return;
        end
        if (draining) return;
        r = row_pos;
        c = (col_pos >= wd) ? 0 : col_pos;
        o = older_rows[c];
        p = prev_rows[c];
        if (r >= 1 && c >= 1) begin
            s = '{0, 0, 0, 0};
            if (c >= 2) begin
                if (r >= 2) s = add_px(s, win_px[0]);
                s = add_px(s, win_px[2]);
                s = add_px(s, win_px[4]);
            end
            if (r >= 2) s = add_px(s, win_px[1]);
            s = add_px(s, win_px[3]);
            s = add_px(s, win_px[5]);
            if (r >= 2) s = add_px(s, o);
            s = add_px(s, p);
            s = add_px(s, w.px);
            blur_expected.push_back(blur_word(s, 1'b0));
        end
        if (r >= 1 && c == wd - 1) begin
            s = '{0, 0, 0, 0};
            if (c >= 1) begin
                if (r >= 2) s = add_px(s, win_px[1]);
                s = add_px(s, win_px[3]);
                s = add_px(s, win_px[5]);
            end
            if (r >= 2) s = add_px(s, o);
            s = add_px(s, p);
            s = add_px(s, w.px);
            blur_expected.push_back(blur_word(s, 1'b0));
        end
        older_rows[c] = p;
        prev_rows[c]  = w.px;
        win_px[0]     = win_px[1];
        win_px[1]     = o;
        win_px[2]     = win_px[3];
        win_px[3]     = p;
        win_px[4]     = win_px[5];
        win_px[5]     = w.px;
        c++;
        if (c >= wd) begin
            c = 0;
            r++;
            if (r >= ht) begin
                r         = 0;
                draining  = 1'b1;
                drain_pos = 0;
            end
        end
        row_pos = r;
        col_pos = c;
    endfunction

    // Both sides pause at random, except in one long window of steady traffic.
    function automatic bit take_break();
        return (cycle_cnt < 3000 || cycle_cnt >= 6000) && $urandom_range(99) < 11;
    endfunction

    function automatic t_pix rand_pix();
        return 24'($urandom);
    endfunction

    task automatic push_pixel(input t_pix px);
        pending_words.push_back({OP_PIXEL, px});
    endtask

    task automatic push_drain();
        pending_words.push_back({OP_DRAIN, rand_pix()});
    endtask

    task automatic write_reg(input logic idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_quiet();
        while (pending_words.size() != 0 || pix_valid || blur_expected.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Driver: predicts each accepted word, then offers the next pending one.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pix_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_FRAME_WIDTH) begin
                    cfg_width = i_cfg_data[FW_W-1:0];
                end else begin
                    cfg_height = i_cfg_data[FH_W-1:0];
                end
                row_pos   = 0;
                col_pos   = 0;
                drain_pos = 0;
                draining  = 1'b0;
            end
            if (pix_valid && pix_bus.ready) begin
                blur_predict(on_bus);
            end
            if (!pix_valid || pix_bus.ready) begin
                if (pending_words.size() != 0 && !take_break()) begin
                    on_bus    <= pending_words.pop_front();
                    pix_valid <= 1'b1;
                end else begin
                    pix_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each result word against the oldest expectation.
    always @(posedge i_clk) begin : result_check
        t_res got, want;
        if (!i_rst_n) begin
            res_ready <= 1'b0;
        end else begin
            if (res_bus.valid && res_ready) begin
                got = {res_bus.red_out, res_bus.green_out, res_bus.blue_out, res_bus.frame_end};
                results_seen++;
                if (blur_expected.size() == 0) begin
                    bad_words++;
                    if (bad_words <= 10) begin
                        $display("unexpected word r=%0d g=%0d b=%0d end=%0d", got.red,
                                 got.green, got.blue, got.frame_end);
                    end
                end else begin
                    want = blur_expected.pop_front();
                    if (got.red !== want.red || got.green !== want.green ||
                        got.blue !== want.blue || got.frame_end !== want.frame_end) begin
                        bad_words++;
                        if (bad_words <= 10) begin
                            $display("word %0d: expected r=%0d g=%0d b=%0d end=%0d, got r=%0d g=%0d b=%0d end=%0d",
                                     results_seen, want.red, want.green, want.blue,
                                     want.frame_end, got.red, got.green, got.blue,
                                     got.frame_end);
                        end
                    end
                end
                // One long hold-off lets the output queue fill and stall the input side.
                if (results_seen == 200) begin
                    hold_left = 120;
                end
            end
            if (hold_left != 0) begin
                hold_left--;
                res_ready <= 1'b0;
            end else if (take_break()) begin
                res_ready <= 1'b0;
                if ($urandom_range(199) == 0) begin
                    hold_left = $urandom_range(60, 20);
                end
            end else begin
                res_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if ((pix_valid && pix_bus.ready) || (res_bus.valid && res_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles == STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        int unsigned wd, ht, frames, npix, ndrain, counted;
        bit          cut, wrote;
        counted = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Default 1024-wide frame: one row plus two pixels, then a restart mid-frame.
        repeat (MAX_W + 2) push_pixel(rand_pix());
        wait_quiet();

        // 3x3 frame with saturated and zero pixels and ignored words on both sides.
        write_reg(CFG_FRAME_WIDTH, 13'd3);
        write_reg(CFG_FRAME_HEIGHT, 13'd3);
        push_drain();
        push_pixel(24'hFFFFFF);
        push_pixel(24'hFFFFFF);
        push_pixel(24'hFFFFFF);
        push_pixel(24'hFFFFFF);
        push_pixel(24'h000000);
        push_pixel(24'hFF00FF);
        push_pixel(24'h010101);
        push_pixel(24'h000000);
        push_pixel(24'h80FF01);
        push_pixel(24'h123456);
        repeat (4) push_drain();
        wait_quiet();

        // Zero sizes clamp to a single pixel.
        write_reg(CFG_FRAME_WIDTH, 13'd0);
        write_reg(CFG_FRAME_HEIGHT, 13'd0);
        push_pixel(24'h00FF00);
        push_drain();
        wait_quiet();

        // Width bits above the register are dropped; one row of two pixels.
        write_reg(CFG_FRAME_WIDTH, 13'h1802);
        write_reg(CFG_FRAME_HEIGHT, 13'd1);
        push_pixel(24'h7F7F7F);
        push_pixel(24'h808080);
        repeat (2) push_drain();
        wait_quiet();

        // Oversized values clamp to the widest row and the tallest column.
        write_reg(CFG_FRAME_WIDTH, 13'd2047);
        repeat (MAX_W) push_pixel(rand_pix());
        repeat (MAX_W) push_drain();
        wait_quiet();
        write_reg(CFG_FRAME_WIDTH, 13'd1);
        write_reg(CFG_FRAME_HEIGHT, 13'd8191);
        repeat (MAX_H) push_pixel(rand_pix());
        push_drain();
        wait_quiet();

        while (counted < ITEM_TARGET) begin
            wrote = 1'b0;
            if (counted == 0 || $urandom_range(1) == 0) begin
                wd = ($urandom_range(9) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 0);
                write_reg(CFG_FRAME_WIDTH, {2'($urandom), 11'(wd)});
                wrote = 1'b1;
            end
            if (counted == 0 || !wrote || $urandom_range(1) == 0) begin
                write_reg(CFG_FRAME_HEIGHT, 13'($urandom_range(8, 0)));
            end
            wd     = used_width();
            ht     = used_height();
            frames = $urandom_range(3, 1);
            for (int f = 0; f < frames; f++) begin
                cut  = ($urandom_range(7) == 0);
                npix = cut ? $urandom_range(wd * ht) : wd * ht;
                for (int i = 0; i < npix; i++) begin
                    if ($urandom_range(31) == 0) push_drain();
                    push_pixel(rand_pix());
                end
                ndrain = 0;
                if (npix == wd * ht) begin
                    ndrain = cut ? $urandom_range(wd - 1) : wd;
                end
                for (int i = 0; i < ndrain; i++) begin
                    if ($urandom_range(31) == 0) push_pixel(rand_pix());
                    push_drain();
                end
                counted += npix + ndrain;
                if (cut) break;
            end
            wait_quiet();
        end

        if (bad_words == 0 && blur_expected.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

### box_blur_3x3_edge_aware_core.f
hw/rtl/bbe_pkg.sv
hw/rtl/bbe_stream_if.sv
hw/rtl/bbe_line_store.sv
hw/rtl/bbe_win_cell.sv
hw/rtl/bbe_out_queue.sv
hw/rtl/box_blur_3x3_edge_aware_core.sv
hw/rtl/bbe_checker.sv
test/testbench.sv
